// ----- design/dllm_pkg.sv -----
// Package for the doubly linked list manager: link format, operation codes
// and the command/response transaction types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dllm_pkg;

	localparam int NODE_W     = 8;
	localparam int NODE_COUNT = 1 << NODE_W;
	localparam int LINK_W     = NODE_W + 1;

	typedef enum logic [2:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_INS_BEFORE = 3'd2,
		OP_INS_AFTER  = 3'd3,
		OP_REM_NEXT   = 3'd4,
		OP_REM_PREV   = 3'd5,
		OP_POP_FRONT  = 3'd6,
		OP_POP_BACK   = 3'd7
	} op_t;

	// a link is either null (all zero) or a valid node index
	typedef struct packed {
		logic              valid;
		logic [NODE_W-1:0] idx;
	} link_t;

	localparam link_t LINK_NULL = '0;

	typedef struct packed {
		op_t               op;
		logic [NODE_W-1:0] node;
		logic              node_present;
		logic [NODE_W-1:0] anchor;
	} cmd_t;

	typedef struct packed {
		logic [NODE_W-1:0] result_node;
		logic              result_present;
		logic [NODE_W-1:0] head_node;
		logic              head_present;
		logic [NODE_W-1:0] tail_node;
		logic              tail_present;
	} rsp_t;

	function automatic link_t mk_link(input logic [NODE_W-1:0] i);
		link_t l;
		l.valid = 1'b1;
		l.idx   = i;
		return l;
	endfunction

endpackage

`default_nettype wire

// ----- design/dllm_ram.sv -----
// Generic single-write, single-read synchronous RAM, read-first, with a
// registered read output. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module dllm_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 9
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ----- design/doubly_linked_list_manager.sv -----
// Doubly linked list manager top level: head/tail registers, two link RAMs
// (next and prev) and the two-step read-modify-write sequencer.
// Depends on dllm_pkg and dllm_ram.
//
//   channel | dir | handshake            | payload
//   cmd     | in  | cmd_valid, cmd_stall | cmd_t (op, node, node_present, anchor)
//   rsp     | out | rsp_valid, rsp_stall | rsp_t (result, head, tail)
//
// Each transaction takes two steps: the accept edge reads both link RAMs at one
// node and does the first link writes; the second step does the writes that
// need the read links and loads the response register. The single write port
// of each link RAM is why the writes are split this way. A stalled response
// holds the second step; a new command can be taken while a finished response
// waits. Reset empties the list; the link RAMs are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module doubly_linked_list_manager (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cmd_valid,
	output logic              cmd_stall,
	input  wire dllm_pkg::cmd_t cmd,
	output logic              rsp_valid,
	input  wire logic         rsp_stall,
	output dllm_pkg::rsp_t    rsp
);

	import dllm_pkg::*;

	typedef enum logic [1:0] {
		ST_ACC = 2'b01,
		ST_EXE = 2'b10
	} state_t;

	state_t state_q;
	link_t  head_q, tail_q;
	logic   rsp_valid_q;
	rsp_t   rsp_q;

	op_t               op_s1;
	logic [NODE_W-1:0] node_s1, anchor_s1, x_s1;
	logic              act_s1;

	logic accept, exe_done;

	// first step (accept edge)
	link_t             me_in, ma_in, end_lnk;
	logic              is_pop_in, act_in;
	logic [NODE_W-1:0] x_in, rd_addr;
	logic              p_wen1, n_wen1;
	logic [NODE_W-1:0] p_wa1, n_wa1;
	link_t             p_wd1, n_wd1;

	// second step
	link_t             p_rd, n_rd, me_s1, x_lnk;
	logic [LINK_W-1:0] p_rdata, n_rdata;
	logic              p_wen2, n_wen2;
	logic [NODE_W-1:0] p_wa2, n_wa2;
	link_t             p_wd2, n_wd2;
	link_t             head_d, tail_d, res_d;
	rsp_t              rsp_d;

	// RAM ports
	logic              p_wen, n_wen;
	logic [NODE_W-1:0] p_wa, n_wa;
	link_t             p_wd, n_wd;

	assign cmd_stall = (state_q != ST_ACC);
	assign accept    = cmd_valid & ~cmd_stall;
	assign exe_done  = (state_q == ST_EXE) & (~rsp_valid_q | ~rsp_stall);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign me_in     = mk_link(cmd.node);
	assign ma_in     = mk_link(cmd.anchor);
	assign end_lnk   = (cmd.op == OP_POP_FRONT) ? head_q : tail_q;
	assign is_pop_in = (cmd.op == OP_POP_FRONT) || (cmd.op == OP_POP_BACK);
	assign act_in    = is_pop_in ? end_lnk.valid : cmd.node_present;
	assign x_in      = is_pop_in ? end_lnk.idx : cmd.node;
	assign rd_addr   = ((cmd.op == OP_INS_BEFORE) || (cmd.op == OP_INS_AFTER)) ?
		cmd.anchor : x_in;

	// writes that need no read data; a later second-step write to the
	// same entry overrides it
	always_comb begin
		p_wen1 = 1'b0;
		p_wa1  = cmd.node;
		p_wd1  = LINK_NULL;
		n_wen1 = 1'b0;
		n_wa1  = cmd.node;
		n_wd1  = LINK_NULL;
		unique case (cmd.op)
			OP_PUSH_FRONT: begin
				p_wen1 = cmd.node_present & head_q.valid;
				p_wa1  = head_q.idx;
				p_wd1  = me_in;
				n_wen1 = cmd.node_present;
				n_wd1  = head_q;
			end
			OP_PUSH_BACK: begin
				p_wen1 = cmd.node_present;
				p_wd1  = tail_q;
				n_wen1 = cmd.node_present & tail_q.valid;
				n_wa1  = tail_q.idx;
				n_wd1  = me_in;
			end
			OP_INS_BEFORE: begin
				p_wen1 = cmd.node_present;
				p_wa1  = cmd.anchor;
				p_wd1  = me_in;
				n_wen1 = cmd.node_present;
				n_wd1  = ma_in;
			end
			OP_INS_AFTER: begin
				p_wen1 = cmd.node_present;
				p_wd1  = ma_in;
				n_wen1 = cmd.node_present;
				n_wa1  = cmd.anchor;
				n_wd1  = me_in;
			end
			default: begin
				// unlink: clear both links of the removed node
				p_wen1 = act_in;
				p_wa1  = x_in;
				n_wen1 = act_in;
				n_wa1  = x_in;
			end
		endcase
	end

	assign p_rd  = link_t'(p_rdata);
	assign n_rd  = link_t'(n_rdata);
	assign me_s1 = mk_link(node_s1);
	assign x_lnk = mk_link(x_s1);

	always_comb begin
		p_wen2 = 1'b0;
		p_wa2  = node_s1;
		p_wd2  = LINK_NULL;
		n_wen2 = 1'b0;
		n_wa2  = node_s1;
		n_wd2  = LINK_NULL;
		head_d = head_q;
		tail_d = tail_q;
		res_d  = LINK_NULL;
		unique case (op_s1)
			OP_PUSH_FRONT: begin
				if (act_s1) begin
					p_wen2 = 1'b1;
					head_d = me_s1;
					if (!head_q.valid) begin
						tail_d = me_s1;
					end
				end
			end
			OP_PUSH_BACK: begin
				if (act_s1) begin
					n_wen2 = 1'b1;
					tail_d = me_s1;
					if (!tail_q.valid) begin
						head_d = me_s1;
					end
				end
			end
			OP_INS_BEFORE: begin
				if (act_s1) begin
					p_wen2 = (node_s1 != anchor_s1);
					p_wd2  = p_rd;
					n_wen2 = p_rd.valid;
					n_wa2  = p_rd.idx;
					n_wd2  = me_s1;
					if (!p_rd.valid) begin
						head_d = me_s1;
					end
				end
			end
			OP_INS_AFTER: begin
				if (act_s1) begin
					n_wen2 = (node_s1 != anchor_s1);
					n_wd2  = n_rd;
					p_wen2 = n_rd.valid;
					p_wa2  = n_rd.idx;
					p_wd2  = me_s1;
					if (!n_rd.valid) begin
						tail_d = me_s1;
					end
				end
			end
			default: begin
				if (act_s1) begin
					// a neighbour equal to the node itself keeps the cleared link
					p_wen2 = n_rd.valid && (n_rd.idx != x_s1);
					p_wa2  = n_rd.idx;
					p_wd2  = p_rd;
					n_wen2 = p_rd.valid && (p_rd.idx != x_s1);
					n_wa2  = p_rd.idx;
					n_wd2  = n_rd;
					if (head_q == x_lnk) begin
						head_d = n_rd;
					end
					if (tail_q == x_lnk) begin
						tail_d = p_rd;
					end
					if (op_s1 == OP_REM_NEXT) begin
						res_d = n_rd;
					end else if (op_s1 == OP_REM_PREV) begin
						res_d = p_rd;
					end else begin
						res_d = x_lnk;
					end
				end
			end
		endcase
	end

	always_comb begin
		rsp_d.result_node    = res_d.valid ? res_d.idx : '0;
		rsp_d.result_present = res_d.valid;
		rsp_d.head_node      = head_d.valid ? head_d.idx : '0;
		rsp_d.head_present   = head_d.valid;
		rsp_d.tail_node      = tail_d.valid ? tail_d.idx : '0;
		rsp_d.tail_present   = tail_d.valid;
	end

	assign p_wen = accept ? p_wen1 : (exe_done & p_wen2);
	assign n_wen = accept ? n_wen1 : (exe_done & n_wen2);
	assign p_wa  = (state_q == ST_EXE) ? p_wa2 : p_wa1;
	assign n_wa  = (state_q == ST_EXE) ? n_wa2 : n_wa1;
	assign p_wd  = (state_q == ST_EXE) ? p_wd2 : p_wd1;
	assign n_wd  = (state_q == ST_EXE) ? n_wd2 : n_wd1;

	dllm_ram #(
		.DEPTH(NODE_COUNT),
		.WIDTH(LINK_W)
	) u_prev_ram (
		.clk    (clk),
		.wr_en  (p_wen),
		.wr_addr(p_wa),
		.wr_data(p_wd),
		.rd_en  (accept),
		.rd_addr(rd_addr),
		.rd_data(p_rdata)
	);

	dllm_ram #(
		.DEPTH(NODE_COUNT),
		.WIDTH(LINK_W)
	) u_next_ram (
		.clk    (clk),
		.wr_en  (n_wen),
		.wr_addr(n_wa),
		.wr_data(n_wd),
		.rd_en  (accept),
		.rd_addr(rd_addr),
		.rd_data(n_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_ACC;
			head_q      <= LINK_NULL;
			tail_q      <= LINK_NULL;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_ACC: begin
					if (accept) begin
						state_q <= ST_EXE;
					end
				end
				ST_EXE: begin
					if (exe_done) begin
						state_q <= ST_ACC;
					end
				end
				default: state_q <= ST_ACC;
			endcase
			if (exe_done) begin
				head_q      <= head_d;
				tail_q      <= tail_d;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1     <= cmd.op;
			node_s1   <= cmd.node;
			anchor_s1 <= cmd.anchor;
			x_s1      <= x_in;
			act_s1    <= act_in;
		end
		if (exe_done) begin
			rsp_q <= rsp_d;
		end
	end

`ifndef ASSERT_OFF
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("sequencer state not one-hot");

	a_accept_to_exe: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_EXE))
		else $error("accepted transaction did not enter second step");

	a_done_to_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		exe_done |=> (rsp_valid && (state_q == ST_ACC)))
		else $error("finished transaction did not present a response");

	a_insert_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(exe_done && ((op_s1 == OP_PUSH_FRONT) || (op_s1 == OP_PUSH_BACK) ||
		(op_s1 == OP_INS_BEFORE) || (op_s1 == OP_INS_AFTER)))
		|=> !rsp.result_present)
		else $error("insert returned a result node");
`endif

endmodule

`default_nettype wire
